### hw/rtl/gwlc_pkg.sv
// Shared types and constants of the windowed gas level classifier.
`default_nettype none
package gwlc_pkg;

    localparam int SAMPLE_BITS    = 10;
    localparam int WINDOW_SAMPLES = 10;
    localparam int POS_BITS       = 4;
    localparam int HIT_BITS       = 4;
    localparam int THR_BITS       = 4;
    localparam int LEVEL_BITS     = 2;
    localparam int REPORT_BITS    = 9;
    localparam int CFG_IDX_BITS   = 8;
    localparam int CFG_DATA_BITS  = 10;
    localparam int S_TDATA_BITS   = 16;
    localparam int M_TDATA_BITS   = 24;

    localparam logic [HIT_BITS-1:0] HITS_MAX = '1;
    localparam logic [POS_BITS-1:0] WINDOW_LAST = POS_BITS'(WINDOW_SAMPLES);

    localparam logic [SAMPLE_BITS-1:0] OFFSET_RESET    = SAMPLE_BITS'(0);
    localparam logic [SAMPLE_BITS-1:0] LOW_LIM_RESET   = SAMPLE_BITS'(300);
    localparam logic [SAMPLE_BITS-1:0] HIGH_LIM_RESET  = SAMPLE_BITS'(600);
    localparam logic [THR_BITS-1:0]    THRESHOLD_RESET = THR_BITS'(7);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ADC_OFFSET      = 8'd0,
        REG_LOW_BAND_LIMIT  = 8'd1,
        REG_HIGH_BAND_LIMIT = 8'd2,
        REG_VOTE_THRESHOLD  = 8'd3
    } t_cfg_reg;

    typedef enum logic [LEVEL_BITS-1:0] {
        LEVEL_CLEAN = 2'd0,
        LEVEL_MID   = 2'd1,
        LEVEL_HIGH  = 2'd2
    } t_level;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] adc_offset;
        logic [SAMPLE_BITS-1:0] low_band_limit;
        logic [SAMPLE_BITS-1:0] high_band_limit;
        logic [THR_BITS-1:0]    vote_threshold;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] corrected_sample;
        logic [LEVEL_BITS-1:0]  alarm_level;
        logic [REPORT_BITS-1:0] reported_level;
        logic                   decision_tick;
    } t_result;

    function automatic logic [HIT_BITS-1:0] bump(input logic [HIT_BITS-1:0] count);
        return (count == HITS_MAX) ? HITS_MAX : count + HIT_BITS'(1);
    endfunction

    // v * 5 / 10 is v / 2; a 10-bit value halved always fits 9 bits
    function automatic logic [REPORT_BITS-1:0] halve(input logic [SAMPLE_BITS-1:0] v);
        return REPORT_BITS'(v >> 1);
    endfunction

endpackage
`default_nettype wire

### hw/rtl/windowed_gas_level_classifier.sv
// Top level of the windowed gas level classifier.
// A sample passes the input register and then the result register before its result is offered.
// Throughput: one sample per cycle while the result side is ready; each sample yields exactly one result.
// Input ready follows the result side's ready combinationally through both registers.
// Synchronous active-low reset clears the window, counts, latched values,
// level and report, and loads the configuration register defaults.
`default_nettype none
module windowed_gas_level_classifier
    import gwlc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output      logic                     s_axis_tready,
    input  wire logic [S_TDATA_BITS-1:0]  s_axis_tdata,  // [9:0] raw_sample
    output      logic                     m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // [9:0] corrected_sample, [11:10] alarm_level, [20:12] reported_level
    output      logic [M_TDATA_BITS-1:0]  m_axis_tdata,
    output      logic                     m_axis_tlast,  // decision_tick
    input  wire logic                     i_cfg_valid,
    output      logic                     o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg                   cfg;
    logic                   front_valid;
    logic [SAMPLE_BITS-1:0] front_corr;
    logic                   take;
    t_result                result;

    assign o_cfg_ready = 1'b1;

    gwlc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gwlc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adc_offset (cfg.adc_offset),
        .i_valid      (s_axis_tvalid),
        .i_raw        (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_ready      (s_axis_tready),
        .i_take       (take),
        .o_valid      (front_valid),
        .o_corr       (front_corr)
    );

    gwlc_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (front_valid),
        .i_corr   (front_corr),
        .o_take   (take),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {3'b000, result.reported_level, result.alarm_level,
                           result.corrected_sample};
    assign m_axis_tlast = result.decision_tick;

endmodule
`default_nettype wire

### hw/rtl/gwlc_cfg.sv
// Configuration register file of the classifier.
`default_nettype none
module gwlc_cfg
    import gwlc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output      t_cfg                     o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ADC_OFFSET:      n_cfg.adc_offset      = i_cfg_data;
                REG_LOW_BAND_LIMIT:  n_cfg.low_band_limit  = i_cfg_data;
                REG_HIGH_BAND_LIMIT: n_cfg.high_band_limit = i_cfg_data;
                REG_VOTE_THRESHOLD:  n_cfg.vote_threshold  = i_cfg_data[THR_BITS-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.adc_offset      <= OFFSET_RESET;
            r_cfg.low_band_limit  <= LOW_LIM_RESET;
            r_cfg.high_band_limit <= HIGH_LIM_RESET;
            r_cfg.vote_threshold  <= THRESHOLD_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### hw/rtl/gwlc_front.sv
// Input register with offset removal and clamp at zero.
`default_nettype none
module gwlc_front
    import gwlc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [SAMPLE_BITS-1:0] i_adc_offset,
    input  wire logic                   i_valid,
    input  wire logic [SAMPLE_BITS-1:0] i_raw,
    output      logic                   o_ready,
    input  wire logic                   i_take,
    output      logic                   o_valid,
    output      logic [SAMPLE_BITS-1:0] o_corr
);

    logic                   r_valid;
    logic [SAMPLE_BITS-1:0] r_corr;
    logic [SAMPLE_BITS-1:0] n_corr;

    assign n_corr  = (i_raw > i_adc_offset) ? i_raw - i_adc_offset : '0;
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_corr <= n_corr;
        end
    end

    assign o_valid = r_valid;
    assign o_corr  = r_corr;

endmodule
`default_nettype wire

### hw/rtl/gwlc_window.sv
// Window state, band vote and result register.
`default_nettype none
module gwlc_window
    import gwlc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire logic                   i_valid,
    input  wire logic [SAMPLE_BITS-1:0] i_corr,
    output      logic                   o_take,
    output      logic                   o_valid,
    input  wire logic                   i_ready,
    output      t_result                o_result
);

    logic [POS_BITS-1:0]    r_pos,  n_pos;
    logic [HIT_BITS-1:0]    r_low_hits,  n_low_hits;
    logic [HIT_BITS-1:0]    r_mid_hits,  n_mid_hits;
    logic [HIT_BITS-1:0]    r_high_hits, n_high_hits;
    logic [SAMPLE_BITS-1:0] r_low_latest,  n_low_latest;
    logic [SAMPLE_BITS-1:0] r_mid_latest,  n_mid_latest;
    logic [SAMPLE_BITS-1:0] r_high_latest, n_high_latest;
    t_level                 r_level, n_level;
    logic [REPORT_BITS-1:0] r_report, n_report;
    logic                   r_out_valid;
    t_result                r_result, n_result;
    logic                   decide;
    logic                   step;

    assign o_take = !r_out_valid || i_ready;
    assign step   = i_valid && o_take;
    assign decide = (r_pos == WINDOW_LAST);

    always_comb begin
        n_pos         = r_pos + POS_BITS'(1);
        n_low_hits    = r_low_hits;
        n_mid_hits    = r_mid_hits;
        n_high_hits   = r_high_hits;
        n_low_latest  = r_low_latest;
        n_mid_latest  = r_mid_latest;
        n_high_latest = r_high_latest;
        n_level       = r_level;
        n_report      = r_report;
        if (decide) begin
            n_pos       = '0;
            n_low_hits  = '0;
            n_mid_hits  = '0;
            n_high_hits = '0;
            if (r_low_hits >= i_cfg.vote_threshold) begin
                n_level  = LEVEL_CLEAN;
                n_report = halve(r_low_latest);
            end else if (r_mid_hits >= i_cfg.vote_threshold) begin
                n_level  = LEVEL_MID;
                n_report = halve(r_mid_latest);
            end else if (r_high_hits >= i_cfg.vote_threshold) begin
                n_level  = LEVEL_HIGH;
                n_report = halve(r_high_latest);
            end
        end else if (i_corr <= i_cfg.low_band_limit) begin
            n_low_hits   = bump(r_low_hits);
            n_low_latest = i_corr;
        end else if (i_corr <= i_cfg.high_band_limit) begin
            n_mid_hits   = bump(r_mid_hits);
            n_mid_latest = i_corr;
        end else begin
            n_high_hits   = bump(r_high_hits);
            n_high_latest = i_corr;
        end
        n_result.corrected_sample = i_corr;
        n_result.alarm_level      = n_level;
        n_result.reported_level   = n_report;
        n_result.decision_tick    = decide;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_low_hits    <= '0;
            r_mid_hits    <= '0;
            r_high_hits   <= '0;
            r_low_latest  <= '0;
            r_mid_latest  <= '0;
            r_high_latest <= '0;
            r_level       <= LEVEL_CLEAN;
            r_report      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (step) begin
                r_pos         <= n_pos;
                r_low_hits    <= n_low_hits;
                r_mid_hits    <= n_mid_hits;
                r_high_hits   <= n_high_hits;
                r_low_latest  <= n_low_latest;
                r_mid_latest  <= n_mid_latest;
                r_high_latest <= n_high_latest;
                r_level       <= n_level;
                r_report      <= n_report;
            end
            if (o_take) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

### hw/rtl/gwlc_checker.sv
// Port-level checks of the classifier and their binding to the top level.
`default_nettype none
module gwlc_checker
    import gwlc_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    s_axis_tready,
    input wire logic                    m_axis_tvalid,
    input wire logic                    m_axis_tready,
    input wire logic [M_TDATA_BITS-1:0] m_axis_tdata,
    input wire logic                    m_axis_tlast
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    a_level_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[11:10] != 2'd3 && m_axis_tdata[23:21] == 3'b000)
        else $error("illegal alarm level or pad bits");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind windowed_gas_level_classifier gwlc_checker u_gwlc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

### sim/gas_level_checker.sv
`timescale 1ns / 100ps
// Predicts and checks every result transfer of the windowed gas level classifier.
module gas_level_checker
    import gwlc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_sample_valid,
    input  wire logic                     i_sample_ready,
    input  wire logic [S_TDATA_BITS-1:0]  i_sample_data,
    input  wire logic                     i_result_valid,
    input  wire logic                     i_result_ready,
    input  wire logic [M_TDATA_BITS-1:0]  i_result_data,
    input  wire logic                     i_result_last,
    input  wire logic                     i_cfg_valid,
    input  wire logic                     i_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    t_cfg                   cfg;
    logic [POS_BITS-1:0]    window_pos;
    logic [HIT_BITS-1:0]    low_hits;
    logic [HIT_BITS-1:0]    mid_hits;
    logic [HIT_BITS-1:0]    high_hits;
    logic [SAMPLE_BITS-1:0] low_latest;
    logic [SAMPLE_BITS-1:0] mid_latest;
    logic [SAMPLE_BITS-1:0] high_latest;
    t_level                 level_now;
    logic [REPORT_BITS-1:0] report_now;
    t_result                expected_levels[$];
    t_result                seen;
    t_result                want;

    function automatic logic [REPORT_BITS-1:0] half_level(input logic [SAMPLE_BITS-1:0] v);
        int h;
        h = (int'(v) * 5) / 10;
        return (h > 511) ? REPORT_BITS'(511) : REPORT_BITS'(h);
    endfunction

    function automatic t_result classify_sample(input logic [SAMPLE_BITS-1:0] raw);
        t_result                r;
        logic [SAMPLE_BITS-1:0] corr;
        corr = (raw > cfg.adc_offset) ? raw - cfg.adc_offset : '0;
        r.decision_tick = 1'b0;
        if (int'(window_pos) < WINDOW_SAMPLES) begin
            window_pos++;
            if (corr <= cfg.low_band_limit) begin
                if (low_hits != HITS_MAX) low_hits++;
                low_latest = corr;
            end else if (corr <= cfg.high_band_limit) begin
                if (mid_hits != HITS_MAX) mid_hits++;
                mid_latest = corr;
            end else begin
                if (high_hits != HITS_MAX) high_hits++;
                high_latest = corr;
            end
        end else begin
            r.decision_tick = 1'b1;
            window_pos = '0;
            if (low_hits >= cfg.vote_threshold) begin
                report_now = half_level(low_latest);
                level_now = LEVEL_CLEAN;
            end else if (mid_hits >= cfg.vote_threshold) begin
                report_now = half_level(mid_latest);
                level_now = LEVEL_MID;
            end else if (high_hits >= cfg.vote_threshold) begin
                report_now = half_level(high_latest);
                level_now = LEVEL_HIGH;
            end
            low_hits = '0;
            mid_hits = '0;
            high_hits = '0;
        end
        r.corrected_sample = corr;
        r.alarm_level = level_now;
        r.reported_level = report_now;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.adc_offset = OFFSET_RESET;
            cfg.low_band_limit = LOW_LIM_RESET;
            cfg.high_band_limit = HIGH_LIM_RESET;
            cfg.vote_threshold = THRESHOLD_RESET;
            window_pos = '0;
            low_hits = '0;
            mid_hits = '0;
            high_hits = '0;
            low_latest = '0;
            mid_latest = '0;
            high_latest = '0;
            level_now = LEVEL_CLEAN;
            report_now = '0;
            expected_levels.delete();
        end else begin
            if (i_result_valid && i_result_ready) begin
                seen.corrected_sample = i_result_data[SAMPLE_BITS-1:0];
                seen.alarm_level = i_result_data[SAMPLE_BITS +: LEVEL_BITS];
                seen.reported_level = i_result_data[SAMPLE_BITS+LEVEL_BITS +: REPORT_BITS];
                seen.decision_tick = i_result_last;
                if (expected_levels.size() == 0) begin
                    $error("result transfer with no sample pending: tdata %h", i_result_data);
                    o_fail_count++;
                end else begin
                    want = expected_levels.pop_front();
                    if (seen.corrected_sample !== want.corrected_sample) begin
                        $error("corrected_sample: expected %0d, got %0d",
                               want.corrected_sample, seen.corrected_sample);
                        o_fail_count++;
                    end
                    if (seen.alarm_level !== want.alarm_level) begin
                        $error("alarm_level: expected %0d, got %0d",
                               want.alarm_level, seen.alarm_level);
                        o_fail_count++;
                    end
                    if (seen.reported_level !== want.reported_level) begin
                        $error("reported_level: expected %0d, got %0d",
                               want.reported_level, seen.reported_level);
                        o_fail_count++;
                    end
                    if (seen.decision_tick !== want.decision_tick) begin
                        $error("decision_tick: expected %0d, got %0d",
                               want.decision_tick, seen.decision_tick);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ADC_OFFSET:      cfg.adc_offset = i_cfg_data;
                    REG_LOW_BAND_LIMIT:  cfg.low_band_limit = i_cfg_data;
                    REG_HIGH_BAND_LIMIT: cfg.high_band_limit = i_cfg_data;
                    REG_VOTE_THRESHOLD:  cfg.vote_threshold = i_cfg_data[THR_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_sample_valid && i_sample_ready) begin
                expected_levels.push_back(classify_sample(i_sample_data[SAMPLE_BITS-1:0]));
            end
        end
        o_pending = expected_levels.size();
    end

endmodule

### sim/windowed_gas_level_classifier_test.sv
`timescale 1ns / 100ps
// Stimulus, flow control and verdict for the windowed gas level classifier.
module windowed_gas_level_classifier_test;
    import gwlc_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] UNMAPPED_REG = 8'd4;
    localparam int WINDOW_TICKS      = WINDOW_SAMPLES + 1;
    localparam int WINDOWS_PER_PHASE = 9;
    localparam int PHASES            = 8;
    localparam int HOLD_CYCLES       = 64;
    localparam int TAIL_CYCLES       = 8;

    localparam logic [SAMPLE_BITS-1:0] DIRECTED [2*WINDOW_TICKS] = '{
        10'd0, 10'd1023, 10'd300, 10'd301, 10'd600, 10'd601,
        10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd555,
        10'd450, 10'd451, 10'd452, 10'd453, 10'd454, 10'd455,
        10'd456, 10'd0, 10'd1023, 10'd1, 10'd1022
    };

    localparam int SET_OFFSET [PHASES-1] = '{0, 1023, 200, 0, 100, 50, 512};
    localparam int SET_LOW    [PHASES-1] = '{300, 0, 500, 1023, 100, 250, 0};
    localparam int SET_HIGH   [PHASES-1] = '{600, 1023, 200, 1023, 400, 700, 0};
    localparam int SET_THR    [PHASES-1] = '{7, 1, 4, 10, 0, 15, 2};

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [S_TDATA_BITS-1:0]  s_axis_tdata = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]  m_axis_tdata;
    logic                     m_axis_tlast;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_asks = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cur_offset = 0;

    windowed_gas_level_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    gas_level_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (s_axis_tvalid),
        .i_sample_ready (s_axis_tready),
        .i_sample_data  (s_axis_tdata),
        .i_result_valid (m_axis_tvalid),
        .i_result_ready (m_axis_tready),
        .i_result_data  (m_axis_tdata),
        .i_result_last  (m_axis_tlast),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #2 i_clk = ~i_clk;

    // hold off the result side for a long stretch on request, else stall at random
    always @(posedge i_clk) begin
        if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic push_sample(input logic [SAMPLE_BITS-1:0] raw);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= S_TDATA_BITS'(raw);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int centre;
        int spread;
        int pick;
        int v;
        bit noisy;
        logic [SAMPLE_BITS-1:0] raw;
        logic [SAMPLE_BITS-1:0] off;
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        logic [THR_BITS-1:0]    thr;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) push_sample(DIRECTED[i]);

        for (int p = 0; p < PHASES; p++) begin
            if (p < PHASES - 1) begin
                off = SAMPLE_BITS'(SET_OFFSET[p]);
                lo = SAMPLE_BITS'(SET_LOW[p]);
                hi = SAMPLE_BITS'(SET_HIGH[p]);
                thr = THR_BITS'(SET_THR[p]);
            end else begin
                off = SAMPLE_BITS'($urandom_range(1023));
                lo = SAMPLE_BITS'($urandom_range(1023));
                hi = SAMPLE_BITS'($urandom_range(1023));
                thr = THR_BITS'($urandom_range(15));
            end
            drain();
            write_reg(REG_ADC_OFFSET, off);
            write_reg(REG_LOW_BAND_LIMIT, lo);
            write_reg(REG_HIGH_BAND_LIMIT, hi);
            // upper data bits are junk for the 4-bit threshold
            write_reg(REG_VOTE_THRESHOLD, {6'($urandom_range(63)), thr});
            write_reg(UNMAPPED_REG, CFG_DATA_BITS'($urandom_range(1023)));
            i_cfg_valid <= 1'b0;
            cur_offset = int'(off);

            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
                default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
            endcase
            if (p == 0) hold_asks++;

            for (int w = 0; w < WINDOWS_PER_PHASE; w++) begin
                noisy = ($urandom_range(99) < 15);
                centre = cur_offset + $urandom_range(1023);
                spread = $urandom_range(40);
                for (int k = 0; k < WINDOW_TICKS; k++) begin
                    pick = $urandom_range(99);
                    if (noisy || pick < 10) begin
                        raw = SAMPLE_BITS'($urandom_range(1023));
                    end else if (pick < 18) begin
                        raw = $urandom_range(1) ? '1 : '0;
                    end else begin
                        v = centre + $urandom_range(2 * spread) - spread;
                        if (v < 0) v = 0;
                        if (v > 1023) v = 1023;
                        raw = SAMPLE_BITS'(v);
                    end
                    push_sample(raw);
                end
            end
        end

        drain();
        rx_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/gwlc_pkg.sv
hw/rtl/gwlc_cfg.sv
hw/rtl/gwlc_front.sv
hw/rtl/gwlc_window.sv
hw/rtl/windowed_gas_level_classifier.sv
hw/rtl/gwlc_checker.sv
sim/gas_level_checker.sv
sim/windowed_gas_level_classifier_test.sv
